[rtl/core/srtf_pkg.sv]
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);

    localparam int ID_W      = 16;
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 12;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 4;
    localparam int STATUS_W  = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RAN      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic cap;
        logic scan;
        logic update;
        logic emit;
    } srtf_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic scan_last;
        logic out_free;
    } srtf_stat_t;

endpackage

[rtl/core/srtf_ctrl.sv]
`timescale 1ns / 1ps

module srtf_ctrl
    import srtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  srtf_stat_t stat,
    output srtf_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.in_tick ? S_SCAN : S_UPDATE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.cap  = s_tvalid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/srtf_datapath.sv]
`timescale 1ns / 1ps

module srtf_datapath
    import srtf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    input  srtf_cmd_t             cmd,
    output srtf_stat_t            stat
);

    // Job table, one entry per slot; slots are filled in order and never reused.
    logic [ID_W-1:0]    id_mem    [MAX_JOBS];
    logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
    logic [BURST_W-1:0] rem_mem   [MAX_JOBS];
    logic [BURST_W-1:0] burst_mem [MAX_JOBS];
    logic [MAX_JOBS-1:0] done_reg;

    logic [CNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]   finished_count_reg;
    logic [TIME_W-1:0]  sim_now_reg;

    logic               func_reg;
    logic [ID_W-1:0]    in_id_reg;
    logic [ARR_W-1:0]   in_arr_reg;
    logic [BURST_W-1:0] in_burst_reg;

    logic [IDX_W-1:0]   scan_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [BURST_W-1:0] best_rem_reg;
    logic [ARR_W-1:0]   best_arr_reg;
    logic [ID_W-1:0]    best_id_reg;
    logic [BURST_W-1:0] best_burst_reg;

    logic               load_ok_reg;
    logic [IDX_W-1:0]   load_slot_reg;
    logic               fin_reg;
    logic [TIME_W-1:0]  tat_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [ID_W-1:0]       out_job_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic                  out_fin_reg;
    logic [TIME_W-1:0]     out_tat_reg;
    logic [TIME_W-1:0]     out_wt_reg;
    logic                  out_all_reg;

    logic               ent_ready;
    logic               ent_better;
    logic [BURST_W-1:0] ent_rem;
    logic [ARR_W-1:0]   ent_arr;
    logic               can_load;
    logic [IDX_W-1:0]   wr_slot;
    logic [BURST_W-1:0] rem_dec;
    logic [TIME_W-1:0]  sim_inc;
    logic [TIME_W-1:0]  tat_next;
    logic [TIME_W-1:0]  wt_val;

    assign ent_rem = rem_mem[scan_idx_reg];
    assign ent_arr = arr_mem[scan_idx_reg];

    // An entry is a candidate when it is loaded, unfinished and has arrived.
    assign ent_ready = ({1'b0, scan_idx_reg} < entry_count_reg)
                     && !done_reg[scan_idx_reg]
                     && ({{(TIME_W-ARR_W){1'b0}}, ent_arr} <= sim_now_reg);
    assign ent_better = !found_reg || (ent_rem < best_rem_reg)
                     || ((ent_rem == best_rem_reg) && (ent_arr < best_arr_reg));

    assign can_load = (entry_count_reg < CNT_W'(MAX_JOBS)) && (in_burst_reg != '0);
    assign wr_slot  = entry_count_reg[IDX_W-1:0];
    assign rem_dec  = best_rem_reg - BURST_W'(1);
    assign sim_inc  = (sim_now_reg == TIME_MAX) ? sim_now_reg : sim_now_reg + TIME_W'(1);
    assign tat_next = sim_inc - {{(TIME_W-ARR_W){1'b0}}, best_arr_reg};
    assign wt_val   = (tat_reg >= {{(TIME_W-BURST_W){1'b0}}, best_burst_reg})
                    ? tat_reg - {{(TIME_W-BURST_W){1'b0}}, best_burst_reg} : '0;

    assign stat.in_tick   = (s_tuser == FUNC_TICK);
    assign stat.scan_last = (scan_idx_reg == IDX_W'(MAX_JOBS - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.update && (func_reg == FUNC_LOAD) && can_load)
        begin
            id_mem[wr_slot]    <= in_id_reg;
            arr_mem[wr_slot]   <= in_arr_reg;
            rem_mem[wr_slot]   <= in_burst_reg;
            burst_mem[wr_slot] <= in_burst_reg;
        end
        else if (cmd.update && (func_reg == FUNC_TICK) && found_reg)
        begin
            rem_mem[best_idx_reg] <= rem_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg           <= '0;
            entry_count_reg    <= '0;
            finished_count_reg <= '0;
            sim_now_reg        <= '0;
            scan_idx_reg       <= '0;
            found_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (ent_ready && ent_better)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.update)
            begin
                if (func_reg == FUNC_LOAD)
                begin
                    if (can_load)
                    begin
                        done_reg[wr_slot] <= 1'b0;
                        entry_count_reg   <= entry_count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    sim_now_reg <= sim_inc;
                    if (found_reg && (rem_dec == '0))
                    begin
                        done_reg[best_idx_reg] <= 1'b1;
                        finished_count_reg     <= finished_count_reg + CNT_W'(1);
                    end
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg     <= s_tuser;
            in_id_reg    <= s_tdata[ID_W-1:0];
            in_arr_reg   <= s_tdata[ID_W+ARR_W-1:ID_W];
            in_burst_reg <= s_tdata[ID_W+ARR_W+BURST_W-1:ID_W+ARR_W];
        end

        if (cmd.scan && ent_ready && ent_better)
        begin
            best_idx_reg   <= scan_idx_reg;
            best_rem_reg   <= ent_rem;
            best_arr_reg   <= ent_arr;
            best_id_reg    <= id_mem[scan_idx_reg];
            best_burst_reg <= burst_mem[scan_idx_reg];
        end

        if (cmd.update)
        begin
            load_ok_reg   <= can_load;
            load_slot_reg <= wr_slot;
            fin_reg       <= found_reg && (rem_dec == '0);
            tat_reg       <= tat_next;
        end

        if (cmd.emit)
        begin
            out_time_reg <= sim_now_reg;
            out_all_reg  <= (finished_count_reg == entry_count_reg);
            out_fin_reg  <= 1'b0;
            out_tat_reg  <= '0;
            out_wt_reg   <= '0;
            if (func_reg == FUNC_LOAD)
            begin
                out_status_reg <= load_ok_reg ? ST_LOADED : ST_REJECTED;
                out_slot_reg   <= load_ok_reg ? SLOT_W'(load_slot_reg) : '0;
                out_job_reg    <= in_id_reg;
            end
            else if (found_reg)
            begin
                out_status_reg <= ST_RAN;
                out_slot_reg   <= SLOT_W'(best_idx_reg);
                out_job_reg    <= best_id_reg;
                out_fin_reg    <= fin_reg;
                if (fin_reg)
                begin
                    out_tat_reg <= tat_reg;
                    out_wt_reg  <= wt_val;
                end
            end
            else
            begin
                out_status_reg <= ST_IDLE;
                out_slot_reg   <= '0;
                out_job_reg    <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_all_reg, out_wt_reg, out_tat_reg, out_fin_reg,
                       out_time_reg, out_job_reg, out_slot_reg};

endmodule

[rtl/core/srtf_scheduler_unit.sv]
`timescale 1ns / 1ps

// Shortest-remaining-time-first job scheduler.
// Input stream (s_*): one request per item. s_tuser selects the function,
// 0 loads a job into the next free slot or refuses it, 1 advances time by one tick.
// Output stream (m_*): exactly one result per request, status in m_tuser.
// A load is captured, updates the table in the update state and has its result
// placed in the output register in the emit state. A tick is captured, scans the
// 16-entry job table one entry per cycle, then updates and emits. One request is
// worked on at a time, and the next is accepted once the current result sits in
// the output register.
// When the receiver stalls, the result is held in the output register and
// the following request completes its work, then waits until the register
// is free before its result is written.
// Reset empties the job table and clears the time counter and all counts; the
// block then accepts requests as soon as reset is released.
module srtf_scheduler_unit
    import srtf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // job_id[15:0], arrival[31:16], burst[43:32], zero fill [47:44]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot[3:0], job_out[19:4], finish_time[51:20], finished[52],
    // turnaround[84:53], waiting[116:85], all_finished[117], zero fill [119:118]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser
);

    srtf_cmd_t  cmd;
    srtf_stat_t stat;

    srtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srtf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

[verif/tb_srtf_scheduler_unit.sv]
`timescale 1ns / 1ps

module tb_srtf_scheduler_unit;
    import srtf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 440;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     job;
        logic [TIME_W-1:0]   finish_time;
        logic                finished;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   waiting;
        logic                all_finished;
    } sched_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = FUNC_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Scheduler state as the testbench predicts it.
    logic [ID_W-1:0]    tbl_id    [MAX_JOBS];
    logic [ARR_W-1:0]   tbl_arr   [MAX_JOBS];
    logic [BURST_W-1:0] tbl_left  [MAX_JOBS];
    logic [BURST_W-1:0] tbl_burst [MAX_JOBS];
    logic               tbl_done  [MAX_JOBS];
    int                 slots_used = 0;
    int                 jobs_done = 0;
    logic [TIME_W-1:0]  sim_clock = '0;

    sched_result_t pending_results[$];

    int  mismatch_count = 0;
    int  unexpected_count = 0;
    int  cycle_count = 0;
    int  loads_seen = 0;
    int  rejects_seen = 0;
    int  runs_seen = 0;
    int  idles_seen = 0;
    int  completions_seen = 0;

    // Stimulus side bookkeeping, kept apart from the predictor to avoid
    // depending on the order in which concurrent processes are run.
    int  jobs_offered = 0;
    int  ticks_offered = 0;
    bit  tx_gap_on = 1'b1;
    bit  rx_stall_on = 1'b1;
    int  hold_left = 0;
    int  rx_wait = 0;

    srtf_scheduler_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic schedule_model(input logic fn, input logic [ID_W-1:0] id,
                                  input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur);
        sched_result_t r;
        bit            found;
        int            best;
        r = '0;
        found = 1'b0;
        best = 0;
        if (fn == FUNC_LOAD)
        begin
            r.job = id;
            if (slots_used >= MAX_JOBS || bur == '0)
            begin
                r.status = ST_REJECTED;
            end
            else
            begin
                tbl_id[slots_used] = id;
                tbl_arr[slots_used] = arr;
                tbl_left[slots_used] = bur;
                tbl_burst[slots_used] = bur;
                tbl_done[slots_used] = 1'b0;
                r.status = ST_LOADED;
                r.slot = slots_used[SLOT_W-1:0];
                slots_used++;
            end
        end
        else
        begin
            for (int i = 0; i < slots_used; i++)
            begin
                if (!tbl_done[i] && TIME_W'(tbl_arr[i]) <= sim_clock)
                begin
                    if (!found || tbl_left[i] < tbl_left[best] ||
                        (tbl_left[i] == tbl_left[best] && tbl_arr[i] < tbl_arr[best]))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                end
            end
            if (sim_clock != TIME_MAX)
                sim_clock++;
            if (!found)
            begin
                r.status = ST_IDLE;
            end
            else
            begin
                r.status = ST_RAN;
                r.slot = best[SLOT_W-1:0];
                r.job = tbl_id[best];
                tbl_left[best]--;
                if (tbl_left[best] == '0)
                begin
                    tbl_done[best] = 1'b1;
                    jobs_done++;
                    r.finished = 1'b1;
                    r.turnaround = sim_clock - TIME_W'(tbl_arr[best]);
                    // Waiting time clamps at zero once the clock has saturated.
                    r.waiting = (r.turnaround >= TIME_W'(tbl_burst[best])) ?
                                r.turnaround - TIME_W'(tbl_burst[best]) : '0;
                end
            end
        end
        r.finish_time = sim_clock;
        r.all_finished = (jobs_done == slots_used);
        pending_results.push_back(r);
    endtask

    // Result checker first, then prediction of the request taken at the same edge.
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.slot = m_tdata[3:0];
            got.job = m_tdata[19:4];
            got.finish_time = m_tdata[51:20];
            got.finished = m_tdata[52];
            got.turnaround = m_tdata[84:53];
            got.waiting = m_tdata[116:85];
            got.all_finished = m_tdata[117];
            case (got.status)
                ST_LOADED:   loads_seen++;
                ST_RAN:      runs_seen++;
                ST_IDLE:     idles_seen++;
                ST_REJECTED: rejects_seen++;
                default:     ;
            endcase
            if (got.status == ST_RAN && got.finished)
                completions_seen++;
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= MAX_REPORTS)
                    $display("Unexpected result at cycle %0d: status %0d slot %0d job %h",
                             cycle_count, got.status, got.slot, got.job);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.status !== exp.status || got.slot !== exp.slot ||
                    got.job !== exp.job || got.finish_time !== exp.finish_time ||
                    got.finished !== exp.finished || got.turnaround !== exp.turnaround ||
                    got.waiting !== exp.waiting || got.all_finished !== exp.all_finished)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= MAX_REPORTS)
                    begin
                        $display("Mismatch at cycle %0d", cycle_count);
                        $display({"  expected: status %0d slot %0d job %h time %0d",
                                  " fin %b tat %0d wt %0d all %b"},
                                 exp.status, exp.slot, exp.job, exp.finish_time, exp.finished,
                                 exp.turnaround, exp.waiting, exp.all_finished);
                        $display({"  actual:   status %0d slot %0d job %h time %0d",
                                  " fin %b tat %0d wt %0d all %b"},
                                 got.status, got.slot, got.job, got.finish_time, got.finished,
                                 got.turnaround, got.waiting, got.all_finished);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            schedule_model(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[43:32]);
    end

    // Receiver: a random stall after each result while stalls are enabled, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            rx_wait = rx_stall_on ? $urandom_range(0, 15) : 0;
            m_tready <= (rx_wait == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            m_tready <= (rx_wait == 0);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Called right after a rising edge; returns at the edge that took the request.
    task automatic send_request(input logic fn, input logic [ID_W-1:0] id,
                                input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {4'b0, bur, arr, id};
        do
            @(posedge clk);
        while (!s_tready);
        if (fn == FUNC_TICK)
            ticks_offered++;
        else if (bur != '0 && jobs_offered < MAX_JOBS)
            jobs_offered++;
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, ID_W'($urandom()), ARR_W'($urandom()), BURST_W'($urandom()));
    endtask

    task automatic test_empty_table();
        send_tick();
        // A zero burst is refused even though the table has room.
        send_request(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 12'd0);
    endtask

    task automatic test_priority_rules();
        // Equal remaining times: the earlier arrival wins, then the lower slot.
        send_request(FUNC_LOAD, 16'h0000, 16'd1, 12'd3);
        send_request(FUNC_LOAD, 16'hFFFF, 16'd0, 12'd3);
        send_request(FUNC_LOAD, 16'h1234, 16'd3, 12'd1);
        send_request(FUNC_LOAD, 16'hBEEF, 16'd1, 12'd3);
        repeat (12) send_tick();
        // An arrival already in the past makes the job ready at once.
        send_request(FUNC_LOAD, 16'h5A5A, 16'd0, 12'd2);
        repeat (3) send_tick();
    endtask

    task automatic test_random_mix();
        logic [ARR_W-1:0] arr;
        int               back;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_gap_on = ~tx_gap_on;
            if ($urandom_range(0, 39) == 0)
                rx_stall_on = ~rx_stall_on;
            if (jobs_offered < MAX_JOBS - 2 && $urandom_range(0, 29) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        back = $urandom_range(0, 10);
                        arr = (ticks_offered > back) ? ARR_W'(ticks_offered - back) : '0;
                    end
                    1:       arr = ARR_W'(ticks_offered);
                    default: arr = ARR_W'(ticks_offered + $urandom_range(1, 15));
                endcase
                send_request(FUNC_LOAD, ID_W'($urandom()), arr,
                             BURST_W'($urandom_range(1, 30)));
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                send_request(FUNC_LOAD, ID_W'($urandom()), ARR_W'($urandom()), 12'd0);
            end
            else
            begin
                send_tick();
            end
        end
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_output_stall();
        @(negedge clk);
        hold_left = 300;
        @(posedge clk);
        tx_gap_on = 1'b0;
        repeat (8) send_tick();
        send_request(FUNC_LOAD, ID_W'($urandom()), ARR_W'($urandom()), 12'd0);
        repeat (4) send_tick();
        tx_gap_on = 1'b1;
    endtask

    task automatic test_table_full();
        while (jobs_offered < MAX_JOBS - 2)
            send_request(FUNC_LOAD, ID_W'($urandom()), ARR_W'(ticks_offered),
                         BURST_W'($urandom_range(1, 8)));
        // This job never becomes ready within the run.
        send_request(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 12'hFFF);
        send_request(FUNC_LOAD, 16'h0000, 16'h0000, 12'hFFF);
        send_request(FUNC_LOAD, 16'hA5A5, 16'h0000, 12'd1);
        send_request(FUNC_LOAD, ID_W'($urandom()), ARR_W'($urandom()), 12'hFFF);
        repeat (30) send_tick();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_priority_rules();
        test_random_mix();
        test_output_stall();
        test_table_full();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Requests: %0d loads taken, %0d refused, %0d ticks ran a job, %0d idle ticks",
                 loads_seen, rejects_seen, runs_seen, idles_seen);
        $display("Jobs completed: %0d of %0d, scheduler time reached %0d, %0d cycles",
                 completions_seen, slots_used, sim_clock, cycle_count);
        if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d unexpected results, %0d missing results",
                     mismatch_count, unexpected_count, pending_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/srtf_pkg.sv
rtl/core/srtf_ctrl.sv
rtl/core/srtf_datapath.sv
rtl/core/srtf_scheduler_unit.sv
verif/tb_srtf_scheduler_unit.sv
